/* rtl/core/bmhq_pkg.sv */
// Shared types and constants of the binary min-heap queue.
package bmhq_pkg;

    // Default sizes of the heap
    localparam int CAPACITY_DEF     = 255;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed widths of the stream fields
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = KEY_W + PAY_W;
    localparam int M_DATA_W = KEY_W + PAY_W + COUNT_W;

    // Request kinds
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_READ,
        ST_UP_CMP,
        ST_DN_ROOT,
        ST_DN_LAST,
        ST_DN_READL,
        ST_DN_READR,
        ST_DN_CMPR,
        ST_RESP
    } state_t;

endpackage

/* rtl/core/binary_min_heap_queue.sv */
// Binary min-heap priority queue held in one synchronous RAM.
//
// Each request is an insert (s_tuser low) or a remove of the minimum entry (s_tuser high);
// each gives exactly one result, with the removed entry, a status code and the number
// of entries held afterward. One request is worked at a time, and s_tready is high
// only while the sequencer is idle; a finished result waits in the output register,
// so the next request may be taken while it is still unclaimed. The single RAM read
// port sets the pace: an insert reads and compares one parent per level it climbs,
// a remove reads the root and the last entry, then the children of each level it
// descends, and a rejected request goes straight to the result state.
// A finished result waits there while the previous one still occupies the output register.
// The heap RAM needs no clearing after reset: only entries up to the fill count are read.
module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // key [31:0], payload [63:32]
    input  logic                s_tuser,  // op [0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // out_key [31:0], out_payload [63:32], count [71:64]
    output logic [STATUS_W-1:0] m_tuser   // status [1:0]
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    state_t               state_reg, state_next;
    logic [IW-1:0]        count_reg, count_next;
    logic [IW-1:0]        pos_reg, pos_next;
    logic [IW-1:0]        child_reg, child_next;
    logic [EW-1:0]        hold_reg, hold_next;
    logic [EW-1:0]        left_reg, left_next;
    logic [KEY_BITS-1:0]  res_key_reg, res_key_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;
    status_t              res_status_reg, res_status_next;

    logic                 m_valid_reg, m_valid_next;
    logic [KEY_W-1:0]     m_key_reg, m_key_next;
    logic [PAY_W-1:0]     m_pay_reg, m_pay_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;
    status_t              m_status_reg, m_status_next;

    logic                 ram_wr_en;
    logic [IW-1:0]        ram_wr_addr;
    logic [EW-1:0]        ram_wr_data;
    logic                 ram_rd_en;
    logic [IW-1:0]        ram_rd_addr;
    logic [EW-1:0]        ram_rd_data;

    logic                 accept;
    logic                 out_free;
    logic [EW-1:0]        in_entry;
    logic [IW:0]          child_w;
    logic                 child_le_used;
    logic                 child_lt_used;
    logic                 up_move;
    logic                 left_move;
    logic                 take_right;
    logic [EW-1:0]        pick;
    logic [IW-1:0]        pick_idx;
    logic                 pick_move;

    bmhq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY + 1)
    ) u_heap_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Handshake and incoming entry
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign in_entry = {KEY_BITS'(s_tdata[KEY_W-1:0]),
                       PAYLOAD_BITS'(s_tdata[S_DATA_W-1:KEY_W])};

    // Heap navigation and key compares
    assign child_w       = {pos_reg, 1'b0};
    assign child_le_used = (child_w <= {1'b0, count_reg});
    assign child_lt_used = (child_w <  {1'b0, count_reg});
    assign up_move   = hold_reg[EW-1:PAYLOAD_BITS] < ram_rd_data[EW-1:PAYLOAD_BITS];
    assign left_move = ram_rd_data[EW-1:PAYLOAD_BITS] < hold_reg[EW-1:PAYLOAD_BITS];
    assign take_right = left_reg[EW-1:PAYLOAD_BITS] > ram_rd_data[EW-1:PAYLOAD_BITS];
    assign pick      = take_right ? ram_rd_data : left_reg;
    assign pick_idx  = take_right ? (child_reg + IW'(1)) : child_reg;
    assign pick_move = pick[EW-1:PAYLOAD_BITS] < hold_reg[EW-1:PAYLOAD_BITS];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (op_t'(s_tuser) == OP_INSERT) begin
                        state_next = (count_reg == IW'(CAPACITY)) ? ST_RESP : ST_UP_READ;
                    end else begin
                        state_next = (count_reg == '0) ? ST_RESP : ST_DN_ROOT;
                    end
                end
            end
            ST_UP_READ: begin
                state_next = (pos_reg == IW'(1)) ? ST_RESP : ST_UP_CMP;
            end
            ST_UP_CMP: begin
                state_next = up_move ? ST_UP_READ : ST_RESP;
            end
            ST_DN_ROOT: begin
                state_next = ST_DN_LAST;
            end
            ST_DN_LAST: begin
                state_next = (count_reg == '0) ? ST_RESP : ST_DN_READL;
            end
            ST_DN_READL: begin
                state_next = child_le_used ? ST_DN_READR : ST_RESP;
            end
            ST_DN_READR: begin
                if (child_lt_used) begin
                    state_next = ST_DN_CMPR;
                end else begin
                    state_next = left_move ? ST_DN_READL : ST_RESP;
                end
            end
            ST_DN_CMPR: begin
                state_next = pick_move ? ST_DN_READL : ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM accesses and result register
    always_comb begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        child_next      = child_reg;
        hold_next       = hold_reg;
        left_next       = left_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_key_next      = m_key_reg;
        m_pay_next      = m_pay_reg;
        m_count_next    = m_count_reg;
        m_status_next   = m_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pos_reg;
        ram_wr_data     = hold_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_key_next    = '0;
                    res_pay_next    = '0;
                    res_status_next = STAT_DONE;
                    if (op_t'(s_tuser) == OP_INSERT) begin
                        if (count_reg == IW'(CAPACITY)) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            count_next = count_reg + IW'(1);
                            pos_next   = count_reg + IW'(1);
                            hold_next  = in_entry;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = STAT_EMPTY;
                        end else begin
                            // fetch the root; the fill count drops now
                            count_next  = count_reg - IW'(1);
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = IW'(1);
                        end
                    end
                end
            end
            ST_UP_READ: begin
                if (pos_reg == IW'(1)) begin
                    ram_wr_en = 1'b1;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pos_reg >> 1;
                end
            end
            ST_UP_CMP: begin
                // move the parent down or drop the new entry in place
                ram_wr_en = 1'b1;
                if (up_move) begin
                    ram_wr_data = ram_rd_data;
                    pos_next    = pos_reg >> 1;
                end
            end
            ST_DN_ROOT: begin
                res_key_next = ram_rd_data[EW-1:PAYLOAD_BITS];
                res_pay_next = ram_rd_data[PAYLOAD_BITS-1:0];
                ram_rd_en    = 1'b1;
                ram_rd_addr  = count_reg + IW'(1);
            end
            ST_DN_LAST: begin
                hold_next = ram_rd_data;
                pos_next  = IW'(1);
            end
            ST_DN_READL: begin
                if (child_le_used) begin
                    child_next  = IW'(child_w);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = IW'(child_w);
                end else begin
                    ram_wr_en = 1'b1;
                end
            end
            ST_DN_READR: begin
                left_next = ram_rd_data;
                if (child_lt_used) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = child_reg + IW'(1);
                end else begin
                    // only a left child: move it up or settle here
                    ram_wr_en = 1'b1;
                    if (left_move) begin
                        ram_wr_data = ram_rd_data;
                        pos_next    = child_reg;
                    end
                end
            end
            ST_DN_CMPR: begin
                ram_wr_en = 1'b1;
                if (pick_move) begin
                    ram_wr_data = pick;
                    pos_next    = pick_idx;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_key_next    = KEY_W'(res_key_reg);
                    m_pay_next    = PAY_W'(res_pay_reg);
                    m_count_next  = COUNT_W'(count_reg);
                    m_status_next = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        child_reg      <= child_next;
        hold_reg       <= hold_next;
        left_reg       <= left_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        res_status_reg <= res_status_next;
        m_key_reg      <= m_key_next;
        m_pay_reg      <= m_pay_next;
        m_count_reg    <= m_count_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_pay_reg, m_key_reg};
    assign m_tuser  = m_status_reg;

endmodule

/* rtl/core/bmhq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module bmhq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/binary_min_heap_queue_tb.sv */
// Self-checking testbench for the binary min-heap queue: stream requests against a heap model.
`timescale 1ns / 1ps

module binary_min_heap_queue_tb
    import bmhq_pkg::*;
();

    localparam int HEAP_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 40;
    localparam int LONG_HOLD    = 600;

    // One expected result of an insert or remove request
    typedef struct {
        logic [KEY_W-1:0]   out_key;
        logic [PAY_W-1:0]   out_pay;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } heap_result_t;

    // Kinds of request mix in the random part
    typedef enum {
        MODE_MIX,
        MODE_FILL,
        MODE_DRAIN
    } mix_mode_t;

    // Heap model plus the queue of results still owed by the block
    class heap_scoreboard;
        logic [KEY_W-1:0] slot_key [1:HEAP_DEPTH];
        logic [PAY_W-1:0] slot_pay [1:HEAP_DEPTH];
        int unsigned      held;
        status_t          last_status;
        heap_result_t     awaited [$];
        int unsigned      mismatches;
        int unsigned      results_checked;

        function new();
            held            = 0;
            mismatches      = 0;
            results_checked = 0;
            last_status     = STAT_DONE;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [KEY_W-1:0] k;
            logic [PAY_W-1:0] p;
            k           = slot_key[a];
            p           = slot_pay[a];
            slot_key[a] = slot_key[b];
            slot_pay[a] = slot_pay[b];
            slot_key[b] = k;
            slot_pay[b] = p;
        endfunction

        // Apply one accepted request to the model and queue its result
        function void note_request(op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
            heap_result_t res;
            int unsigned  pos;
            int unsigned  child;
            res.out_key = '0;
            res.out_pay = '0;
            res.status  = STAT_DONE;
            if (op == OP_INSERT) begin
                if (held >= HEAP_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    held           = held + 1;
                    pos            = held;
                    slot_key[pos]  = key;
                    slot_pay[pos]  = pay;
                    // climb while strictly smaller than the parent
                    while (pos > 1 && slot_key[pos] < slot_key[pos / 2]) begin
                        swap_slots(pos, pos / 2);
                        pos = pos / 2;
                    end
                end
            end else if (held == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                res.out_key = slot_key[1];
                res.out_pay = slot_pay[1];
                slot_key[1] = slot_key[held];
                slot_pay[1] = slot_pay[held];
                held        = held - 1;
                pos         = 1;
                child       = 2;
                // descend, left child wins ties, swap only when strictly smaller
                while (child <= held) begin
                    if (child < held && slot_key[child] > slot_key[child + 1])
                        child = child + 1;
                    if (!(slot_key[child] < slot_key[pos]))
                        break;
                    swap_slots(child, pos);
                    pos   = child;
                    child = 2 * pos;
                end
            end
            res.count   = COUNT_W'(held);
            last_status = res.status;
            awaited.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one result from the block with the oldest outstanding one
        task check_result(logic [M_DATA_W-1:0] data, logic [STATUS_W-1:0] code);
            heap_result_t want;
            results_checked++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result %0d with no request outstanding",
                                          results_checked));
                return;
            end
            want = awaited.pop_front();
            if (data[KEY_W-1:0] !== want.out_key)
                report_mismatch($sformatf("result %0d key %h, want %h", results_checked,
                                          data[KEY_W-1:0], want.out_key));
            if (data[KEY_W+PAY_W-1:KEY_W] !== want.out_pay)
                report_mismatch($sformatf("result %0d payload %h, want %h", results_checked,
                                          data[KEY_W+PAY_W-1:KEY_W], want.out_pay));
            if (data[M_DATA_W-1:KEY_W+PAY_W] !== want.count)
                report_mismatch($sformatf("result %0d count %0d, want %0d", results_checked,
                                          data[M_DATA_W-1:KEY_W+PAY_W], want.count));
            if (code !== want.status)
                report_mismatch($sformatf("result %0d status %0d, want %0d", results_checked,
                                          code, want.status));
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // key [31:0], payload [63:32]
    logic                s_tuser;   // op [0]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // out_key [31:0], out_payload [63:32], count [71:64]
    logic [STATUS_W-1:0] m_tuser;   // status [1:0]

    heap_scoreboard board;
    int unsigned    cycle_count;
    int unsigned    burst_left;

    binary_min_heap_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Pick a sender gap: mostly none or short, a few long, none during a burst
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_left > 0)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Pick a key: narrow ranges force ties, the rest spans all bits
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return KEY_W'($urandom_range(0, 15));
        if (roll < 45)
            return '0;
        if (roll < 50)
            return '1;
        if (roll < 55)
            return ~KEY_W'($urandom_range(0, 7));
        return KEY_W'($urandom());
    endfunction

    // Offer one request after an idle gap and hold it until accepted
    task send_request(op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pay, key};
        do @(posedge aclk); while (!s_tready);
        board.note_request(op, key, pay);
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(0, 99) == 0)
            burst_left = $urandom_range(20, 80);
    endtask

    // Result side: check accepted results and randomize backpressure
    initial begin : result_side
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned ready_pct;
        int unsigned mode_cycles;
        bit          hold_done;
        hold_left   = 0;
        stall_left  = 0;
        ready_pct   = 100;
        mode_cycles = 0;
        hold_done   = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            // hold off once for a long stretch so the block backs up into its input
            if (!hold_done && board.results_checked >= 60) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_cycles == 0) begin
                mode_cycles = 256;
                case ($urandom_range(0, 2))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    default: ready_pct = 30;
                endcase
            end
            mode_cycles--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 299) == 0)
                    stall_left = $urandom_range(20, 60);
                m_tready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // Request side: reset, directed requests, then random phases
    initial begin : request_side
        mix_mode_t   mode;
        int unsigned mode_left;
        int unsigned rejects;
        op_t         op;
        int          roll;
        board       = new();
        cycle_count = 0;
        burst_left  = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_INSERT;
        s_tdata  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // remove from an empty heap
        send_request(OP_REMOVE, '0, '0, pick_gap());
        // field extremes, equal keys, and a new minimum
        send_request(OP_INSERT, '1, '0, pick_gap());
        send_request(OP_INSERT, '0, '1, pick_gap());
        send_request(OP_INSERT, 32'd5, 32'h0000_000a, pick_gap());
        send_request(OP_INSERT, 32'd5, 32'h0000_000b, pick_gap());
        send_request(OP_INSERT, 32'd5, 32'h0000_000c, pick_gap());
        send_request(OP_INSERT, 32'd3, 32'h5555_aaaa, pick_gap());
        send_request(OP_INSERT, 32'h8000_0000, 32'haaaa_5555, pick_gap());
        send_request(OP_INSERT, 32'd5, 32'h0000_000d, pick_gap());
        // drain in order, ties between children go left, then one more from empty
        repeat (9) send_request(OP_REMOVE, '1, '1, pick_gap());

        // random part: mixed traffic, then fill past full, then drain past empty
        mode      = MODE_MIX;
        mode_left = 150;
        rejects   = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 9);
            case (mode)
                MODE_MIX:   op = (roll < 5) ? OP_INSERT : OP_REMOVE;
                MODE_FILL:  op = (roll < 9) ? OP_INSERT : OP_REMOVE;
                default:    op = (roll < 1) ? OP_INSERT : OP_REMOVE;
            endcase
            send_request(op, pick_key(), PAY_W'($urandom()), pick_gap());
            case (mode)
                MODE_MIX: begin
                    mode_left--;
                    if (mode_left == 0) begin
                        mode    = MODE_FILL;
                        rejects = 0;
                    end
                end
                MODE_FILL: begin
                    if (board.last_status == STAT_FULL)
                        rejects++;
                    if (rejects == 3) begin
                        mode    = MODE_DRAIN;
                        rejects = 0;
                    end
                end
                default: begin
                    if (board.last_status == STAT_EMPTY)
                        rejects++;
                    if (rejects == 3) begin
                        mode      = MODE_MIX;
                        mode_left = $urandom_range(100, 200);
                    end
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // wait for every outstanding result, then let the block settle
        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* binary_min_heap_queue.f */
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ram.sv
rtl/core/binary_min_heap_queue.sv
tb/binary_min_heap_queue_tb.sv
